/* design/lgsm_pkg.sv */
package lgsm_pkg;

    // Field widths of the register, the input item and the result item.
    localparam int DIST_BITS = 16;
    localparam int OUT_BITS  = 32;

    // Width of the elapsed-time counter; the counter saturates at all ones.
    localparam int TIME_BITS = 32;

    // Scale from cm per microsecond to hundredths of km/h.
    localparam int                   SCALE_BITS  = 22;
    localparam logic [SCALE_BITS-1:0] SPEED_SCALE = SCALE_BITS'(3600000);

    // The dividend is distance times scale.
    localparam int PROD_BITS = DIST_BITS + SCALE_BITS;
    localparam int STEP_BITS = $clog2(PROD_BITS);

    // Register reset value.
    localparam logic [DIST_BITS-1:0] DIST_RESET = DIST_BITS'(100);

    // Saturated speed.
    localparam logic [OUT_BITS-1:0] SPEED_MAX = '1;

    // Input command codes.
    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    // Request queue between front and back; depth is a power of two.
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    // One classified request from the front to the back.
    typedef struct packed {
        logic                 measure;
        logic [TIME_BITS-1:0] elapsed;
    } lgsm_req_t;

endpackage

/* design/lgsm_front.sv */
module lgsm_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_command,
    input  logic                s_start_broken,
    input  logic                s_end_broken,
    output logic                q_push,
    output lgsm_pkg::lgsm_req_t q_data,
    input  logic                q_full
);

    logic                           start_seen_reg, start_seen_next;
    logic                           end_seen_reg, end_seen_next;
    logic                           armed_reg, armed_next;
    logic [lgsm_pkg::TIME_BITS-1:0] count_reg, count_next;
    logic                           accept;
    logic                           start_edge;
    logic                           end_edge;
    logic                           armed_mid;
    logic [lgsm_pkg::TIME_BITS-1:0] count_mid;
    logic                           measure;

    // A request is taken whenever the queue has room.
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;

    // Edge detection and the elapsed counter for one tick.
    always_comb begin
        start_edge = s_start_broken && !start_seen_reg;
        end_edge   = s_end_broken && !end_seen_reg;
        if (start_edge) begin
            armed_mid = 1'b1;
            count_mid = '0;
        end else begin
            armed_mid = armed_reg;
            if (armed_reg && (count_reg != '1)) begin
                count_mid = count_reg + lgsm_pkg::TIME_BITS'(1);
            end else begin
                count_mid = count_reg;
            end
        end
        measure = end_edge && armed_mid;

        if (s_command == lgsm_pkg::CMD_CLEAR) begin
            start_seen_next = 1'b0;
            end_seen_next   = 1'b0;
            armed_next      = 1'b0;
            count_next      = '0;
            q_data.measure  = 1'b0;
        end else begin
            start_seen_next = s_start_broken;
            // The end level is not recorded on a measuring tick.
            end_seen_next   = s_end_broken && !measure;
            armed_next      = armed_mid && !measure;
            count_next      = count_mid;
            q_data.measure  = measure;
        end
        q_data.elapsed = count_mid;
        q_push         = accept;
    end

    // State registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_seen_reg <= 1'b0;
            end_seen_reg   <= 1'b0;
            armed_reg      <= 1'b0;
            count_reg      <= '0;
        end else if (accept) begin
            start_seen_reg <= start_seen_next;
            end_seen_reg   <= end_seen_next;
            armed_reg      <= armed_next;
            count_reg      <= count_next;
        end
    end

endmodule

/* design/lgsm_fifo.sv */
module lgsm_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  lgsm_pkg::lgsm_req_t push_data,
    output logic                full,
    input  logic                pop,
    output lgsm_pkg::lgsm_req_t pop_data,
    output logic                not_empty
);

    lgsm_pkg::lgsm_req_t             slot_reg [lgsm_pkg::QUEUE_DEPTH];
    logic [lgsm_pkg::QUEUE_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [lgsm_pkg::QUEUE_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [lgsm_pkg::QUEUE_AW:0]     count_reg, count_next;
    logic                            do_push;
    logic                            do_pop;

    assign full      = (count_reg == (lgsm_pkg::QUEUE_AW + 1)'(lgsm_pkg::QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // Pointers wrap naturally since the depth is a power of two.
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + lgsm_pkg::QUEUE_AW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + lgsm_pkg::QUEUE_AW'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (lgsm_pkg::QUEUE_AW + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (lgsm_pkg::QUEUE_AW + 1)'(1);
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* design/lgsm_back.sv */
module lgsm_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [lgsm_pkg::DIST_BITS-1:0]      gate_distance_cm,
    input  logic                                q_valid,
    input  lgsm_pkg::lgsm_req_t                 q_data,
    output logic                                q_pop,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_speed_valid,
    output logic [lgsm_pkg::OUT_BITS-1:0]       m_speed_centi_kmph,
    output logic [lgsm_pkg::OUT_BITS-1:0]       m_elapsed_us
);

    typedef enum logic [3:0] {
        B_IDLE = 4'b0001,
        B_MUL  = 4'b0010,
        B_DIV  = 4'b0100,
        B_DONE = 4'b1000
    } back_state_t;

    back_state_t                       state_reg, state_next;
    logic                              meas_reg, meas_next;
    logic                              sat_reg, sat_next;
    logic [lgsm_pkg::TIME_BITS-1:0]    div_reg, div_next;
    logic [lgsm_pkg::PROD_BITS-1:0]    num_reg, num_next;
    logic [lgsm_pkg::TIME_BITS-1:0]    rem_reg, rem_next;
    logic [lgsm_pkg::STEP_BITS-1:0]    step_reg, step_next;
    logic                              m_valid_reg, m_valid_next;
    logic                              m_speed_valid_reg;
    logic [lgsm_pkg::OUT_BITS-1:0]     m_speed_reg;
    logic [lgsm_pkg::OUT_BITS-1:0]     m_elapsed_reg;
    logic [lgsm_pkg::OUT_BITS-1:0]     speed_value;
    logic [lgsm_pkg::PROD_BITS-1:0]    product;
    logic [lgsm_pkg::TIME_BITS:0]      rem_shift;
    logic [lgsm_pkg::TIME_BITS:0]      rem_diff;
    logic                              rem_ge;
    logic                              out_load;

    // Dividend: distance times the scale constant.
    assign product = gate_distance_cm * lgsm_pkg::SPEED_SCALE;

    // One restoring division step: shift in the next dividend bit, try a subtract.
    assign rem_shift = {rem_reg, num_reg[lgsm_pkg::PROD_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, div_reg};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});

    // Quotient saturates when it does not fit the output field.
    always_comb begin
        if (sat_reg || (num_reg[lgsm_pkg::PROD_BITS-1:lgsm_pkg::OUT_BITS] != '0)) begin
            speed_value = lgsm_pkg::SPEED_MAX;
        end else begin
            speed_value = num_reg[lgsm_pkg::OUT_BITS-1:0];
        end
    end

    assign out_load = (state_reg == B_DONE) && (!m_valid_reg || m_ready);

    // Sequencer for one request.
    always_comb begin
        state_next = state_reg;
        meas_next  = meas_reg;
        sat_next   = sat_reg;
        div_next   = div_reg;
        num_next   = num_reg;
        rem_next   = rem_reg;
        step_next  = step_reg;
        q_pop      = 1'b0;
        case (state_reg)
            B_IDLE: begin
                if (q_valid) begin
                    q_pop     = 1'b1;
                    meas_next = q_data.measure;
                    div_next  = q_data.elapsed;
                    num_next  = '0;
                    sat_next  = 1'b0;
                    if (!q_data.measure) begin
                        state_next = B_DONE;
                    end else if (q_data.elapsed == '0) begin
                        // Zero time gives the saturated speed.
                        sat_next   = 1'b1;
                        state_next = B_DONE;
                    end else begin
                        state_next = B_MUL;
                    end
                end
            end
            B_MUL: begin
                num_next   = product;
                rem_next   = '0;
                step_next  = lgsm_pkg::STEP_BITS'(lgsm_pkg::PROD_BITS - 1);
                state_next = B_DIV;
            end
            B_DIV: begin
                num_next  = {num_reg[lgsm_pkg::PROD_BITS-2:0], rem_ge};
                rem_next  = rem_ge ? rem_diff[lgsm_pkg::TIME_BITS-1:0]
                                   : rem_shift[lgsm_pkg::TIME_BITS-1:0];
                step_next = step_reg - lgsm_pkg::STEP_BITS'(1);
                if (step_reg == '0) begin
                    state_next = B_DONE;
                end
            end
            B_DONE: begin
                if (out_load) begin
                    state_next = B_IDLE;
                end
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase
    end

    // Output valid: set on load, cleared once the result is taken.
    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        meas_reg <= meas_next;
        sat_reg  <= sat_next;
        div_reg  <= div_next;
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        step_reg <= step_next;
    end

    // Output register; fields read zero when no measurement completed.
    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_speed_valid_reg <= meas_reg;
            m_speed_reg       <= meas_reg ? speed_value : '0;
            m_elapsed_reg     <= meas_reg ? lgsm_pkg::OUT_BITS'(div_reg) : '0;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_speed_valid      = m_speed_valid_reg;
    assign m_speed_centi_kmph = m_speed_reg;
    assign m_elapsed_us       = m_elapsed_reg;

endmodule

/* design/light_gate_speed_meter_top.sv */
// Flow: an accepted request is written into the queue, popped by the back part when idle,
// and its result loaded into the output register; a measuring tick passes through the
// multiply state and the one-bit-per-cycle divider first. The back part takes a new request
// only once the last result is loaded. Input is taken while the two-entry queue has room.
// Reset (aresetn, synchronous, active low) clears the edge state, counter, queue
// and output valid, and sets gate_distance_cm to 100.
module light_gate_speed_meter_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [lgsm_pkg::DIST_BITS-1:0]    cfg_wr_data,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_command,
    input  logic                              s_start_broken,
    input  logic                              s_end_broken,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic                              m_speed_valid,
    output logic [lgsm_pkg::OUT_BITS-1:0]     m_speed_centi_kmph,
    output logic [lgsm_pkg::OUT_BITS-1:0]     m_elapsed_us
);

    logic [lgsm_pkg::DIST_BITS-1:0] dist_reg;
    logic                           q_push;
    lgsm_pkg::lgsm_req_t            q_push_data;
    logic                           q_full;
    logic                           q_pop;
    lgsm_pkg::lgsm_req_t            q_pop_data;
    logic                           q_valid;

    // Gate distance register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dist_reg <= lgsm_pkg::DIST_RESET;
        end else if (cfg_wr_en) begin
            dist_reg <= cfg_wr_data;
        end
    end

    // Front: edge detection and classification of each tick.
    lgsm_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_start_broken (s_start_broken),
        .s_end_broken   (s_end_broken),
        .q_push         (q_push),
        .q_data         (q_push_data),
        .q_full         (q_full)
    );

    // Request queue between front and back.
    lgsm_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .not_empty (q_valid)
    );

    // Back: speed division and result output.
    lgsm_back u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .gate_distance_cm   (dist_reg),
        .q_valid            (q_valid),
        .q_data             (q_pop_data),
        .q_pop              (q_pop),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_speed_valid      (m_speed_valid),
        .m_speed_centi_kmph (m_speed_centi_kmph),
        .m_elapsed_us       (m_elapsed_us)
    );

endmodule
